// File: sv/wheel_speed_inverse_kinematics_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wheel speed inverse kinematics block
// Shared property forms used by the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_INVERSE_KINEMATICS_DEFINES_SVH
`define WHEEL_SPEED_INVERSE_KINEMATICS_DEFINES_SVH

// a word seen now must come out after exactly the delay n
`define WSIK_ASSERT_DELAY(lbl, clk, rst_n, a, n, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (c)) \
        else $error("word lost in pipeline");

// a word out now must have entered exactly the delay n earlier
`define WSIK_ASSERT_PAST(lbl, clk, rst_n, c, a, n) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (c) |-> $past(a, n)) \
        else $error("word invented in pipeline");

`endif

// File: sv/wsik_pkg.sv
// ----------------------------------------------------------------------------
// wsik_pkg
// Types and fixed constants of the wheel speed inverse kinematics block.
// ----------------------------------------------------------------------------
package wsik_pkg;

    localparam int NUM_WHEELS  = 4;
    localparam int TRACK_BITS  = 12;
    localparam int SPAN_BITS   = 13;
    localparam int LIMIT_BITS  = 15;
    localparam int QUOT_BITS   = 15;
    localparam int ROT_SHIFT   = 11;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 15;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TRACK = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_WHEEL = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LIMIT = 2'd3;

    localparam logic                  RST_MODE  = 1'b1;
    localparam logic [TRACK_BITS-1:0] RST_TRACK = 12'd200;
    localparam logic [TRACK_BITS-1:0] RST_WHEEL = 12'd200;
    localparam logic [LIMIT_BITS-1:0] RST_LIMIT = 15'd1000;

    typedef struct packed {
        logic                  valid;
        logic [NUM_WHEELS-1:0] neg;
    } t_div_ctrl;

endpackage

// File: sv/wsik_divider.sv
// ----------------------------------------------------------------------------
// wsik_divider
// Four-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module wsik_divider
    import wsik_pkg::*;
#(
    parameter int DEN_BITS = 19
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  t_div_ctrl                                         i_ctrl,
    input  logic [NUM_WHEELS-1:0][DEN_BITS+LIMIT_BITS-1:0]    i_num,
    input  logic [DEN_BITS-1:0]                               i_den,
    output t_div_ctrl                                         o_ctrl,
    output logic [NUM_WHEELS-1:0][QUOT_BITS-1:0]              o_quot
);

    localparam int NW = DEN_BITS + LIMIT_BITS;
    localparam int QB = QUOT_BITS;

    logic [NUM_WHEELS-1:0][NW-1:0]  w_rem [0:QB-1];
    logic [DEN_BITS-1:0]            w_den [0:QB-1];
    logic [NUM_WHEELS-1:0][QB-1:0]  w_q   [0:QB];
    t_div_ctrl                      w_ctrl[0:QB];

    t_div_ctrl                      r_ctrl[1:QB];
    logic [NUM_WHEELS-1:0][QB-1:0]  r_q   [1:QB];

    assign w_rem[0]  = i_num;
    assign w_den[0]  = i_den;
    assign w_q[0]    = '0;
    assign w_ctrl[0] = i_ctrl;

    genvar gi;
    generate
        for (gi = 0; gi < QB; gi++) begin : g_step
            localparam int SH = QB - 1 - gi;
            logic [NW-1:0]                  w_dsh;
            logic [NUM_WHEELS-1:0]          w_ge;
            logic [NUM_WHEELS-1:0][NW-1:0]  n_rem;

            assign w_dsh = NW'(w_den[gi]) << SH;

            always_comb begin
                for (int l = 0; l < NUM_WHEELS; l++) begin
                    w_ge[l]  = (w_rem[gi][l] >= w_dsh);
                    n_rem[l] = w_ge[l] ? (w_rem[gi][l] - w_dsh) : w_rem[gi][l];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_ctrl[gi+1].valid <= 1'b0;
                end else begin
                    r_ctrl[gi+1].valid <= w_ctrl[gi].valid;
                end
                r_ctrl[gi+1].neg <= w_ctrl[gi].neg;
                for (int l = 0; l < NUM_WHEELS; l++) begin
                    r_q[gi+1][l] <= {w_q[gi][l][QB-2:0], w_ge[l]};
                end
            end

            assign w_ctrl[gi+1] = r_ctrl[gi+1];
            assign w_q[gi+1]    = r_q[gi+1];

            if (gi < QB - 1) begin : g_carry
                logic [NUM_WHEELS-1:0][NW-1:0] r_rem;
                logic [DEN_BITS-1:0]           r_den;
                always_ff @(posedge i_clk) begin
                    r_rem <= n_rem;
                    r_den <= w_den[gi];
                end
                assign w_rem[gi+1] = r_rem;
                assign w_den[gi+1] = r_den;
            end
        end
    endgenerate

    assign o_ctrl = w_ctrl[QB];
    assign o_quot = w_q[QB];

endmodule

// File: sv/wheel_speed_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// wheel_speed_inverse_kinematics
// Body velocity command to four limited wheel speeds, mecanum or differential.
// ----------------------------------------------------------------------------
// A word is taken at every clock edge with start high; busy is high only while
// reset is held, so one command per cycle is sustained. Each result appears on
// the outputs with o_valid high for one cycle, after its command has passed
// through the registered span multiply, wheel sums, magnitude, maximum, limit
// check and scaling multiply, then fifteen stages of the restoring divider (one
// quotient bit each), then the sign stage. The output side cannot stall. Write
// the configuration registers only while no word is in flight.
module wheel_speed_inverse_kinematics
    import wsik_pkg::*;
#(
    parameter int VELOCITY_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [VELOCITY_BITS-1:0] i_lateral_velocity,
    input  logic signed [VELOCITY_BITS-1:0] i_forward_velocity,
    input  logic signed [VELOCITY_BITS-1:0] i_yaw_rate,
    input  logic                            i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0]        i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]        i_cfg_data,
    output logic                            o_valid,
    output logic signed [VELOCITY_BITS-1:0] o_left_front_speed,
    output logic signed [VELOCITY_BITS-1:0] o_left_back_speed,
    output logic signed [VELOCITY_BITS-1:0] o_right_front_speed,
    output logic signed [VELOCITY_BITS-1:0] o_right_back_speed
);

`include "wheel_speed_inverse_kinematics_defines.svh"

    localparam int VB  = VELOCITY_BITS;
    localparam int PW  = VB + SPAN_BITS + 1;
    localparam int RW  = PW - ROT_SHIFT;
    localparam int WW  = VB + 4;
    localparam int MW  = VB + 3;
    localparam int NW  = MW + LIMIT_BITS;
    localparam int LAT = 7 + QUOT_BITS;

    // configuration
    logic                  r_mode;
    logic [TRACK_BITS-1:0] r_track;
    logic [TRACK_BITS-1:0] r_wheel;
    logic [LIMIT_BITS-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= RST_MODE;
            r_track <= RST_TRACK;
            r_wheel <= RST_WHEEL;
            r_limit <= RST_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:  r_mode  <= i_cfg_data[0];
                CFG_TRACK: r_track <= i_cfg_data[TRACK_BITS-1:0];
                CFG_WHEEL: r_wheel <= i_cfg_data[TRACK_BITS-1:0];
                CFG_LIMIT: r_limit <= i_cfg_data[LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign busy = ~i_rst_n;

    // stage 1: rotation product
    logic [SPAN_BITS-1:0]   w_span;
    logic signed [PW-1:0]   w_prod;
    logic                   r_v1;
    logic                   r_mode1;
    logic signed [VB-1:0]   r_x1;
    logic signed [VB-1:0]   r_y1;
    logic signed [PW-1:0]   r_p1;

    assign w_span = r_mode ? (SPAN_BITS'(r_track) + SPAN_BITS'(r_wheel))
                           : SPAN_BITS'(r_wheel);
    assign w_prod = PW'(i_yaw_rate) * $signed(PW'(w_span));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start & ~busy;
        end
        r_mode1 <= r_mode;
        r_x1    <= i_lateral_velocity;
        r_y1    <= i_forward_velocity;
        r_p1    <= w_prod;
    end

    // stage 2: wheel sums
    logic signed [RW-1:0]   w_rot;
    logic signed [WW-1:0]   w_rx;
    logic signed [WW-1:0]   w_ry;
    logic signed [WW-1:0]   w_rr;
    logic                   r_v2;
    logic signed [WW-1:0]   r_wv2 [0:NUM_WHEELS-1];

    assign w_rot = r_p1[PW-1:ROT_SHIFT];
    assign w_rx  = r_mode1 ? WW'(r_x1) : '0;
    assign w_ry  = WW'(r_y1);
    assign w_rr  = WW'(w_rot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_wv2[0] <=  w_rx + w_ry - w_rr;
        r_wv2[1] <= -w_rx + w_ry - w_rr;
        r_wv2[2] <= -w_rx + w_ry + w_rr;
        r_wv2[3] <=  w_rx + w_ry + w_rr;
    end

    // stage 3: magnitudes
    logic                   r_v3;
    logic [MW-1:0]          r_mag3 [0:NUM_WHEELS-1];
    logic [NUM_WHEELS-1:0]  r_neg3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        for (int l = 0; l < NUM_WHEELS; l++) begin
            r_neg3[l] <= r_wv2[l][WW-1];
            r_mag3[l] <= r_wv2[l][WW-1] ? MW'(-r_wv2[l]) : MW'(r_wv2[l]);
        end
    end

    // stage 4: largest magnitude
    logic [MW-1:0]          w_m01;
    logic [MW-1:0]          w_m23;
    logic                   r_v4;
    logic [MW-1:0]          r_max4;
    logic [MW-1:0]          r_mag4 [0:NUM_WHEELS-1];
    logic [NUM_WHEELS-1:0]  r_neg4;

    assign w_m01 = (r_mag3[0] > r_mag3[1]) ? r_mag3[0] : r_mag3[1];
    assign w_m23 = (r_mag3[2] > r_mag3[3]) ? r_mag3[2] : r_mag3[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_max4 <= (w_m01 > w_m23) ? w_m01 : w_m23;
        r_mag4 <= r_mag3;
        r_neg4 <= r_neg3;
    end

    // stage 5: limit check; unscaled words divide by one
    logic                   w_scale;
    logic                   r_v5;
    logic [LIMIT_BITS-1:0]  r_fac5;
    logic [MW-1:0]          r_den5;
    logic [MW-1:0]          r_mag5 [0:NUM_WHEELS-1];
    logic [NUM_WHEELS-1:0]  r_neg5;

    assign w_scale = (r_max4 > MW'(r_limit));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        r_fac5 <= w_scale ? r_limit : LIMIT_BITS'(1);
        r_den5 <= w_scale ? r_max4 : MW'(1);
        r_mag5 <= r_mag4;
        r_neg5 <= r_neg4;
    end

    // stage 6: scaling multiply
    t_div_ctrl                      r_ctrl6;
    logic [NUM_WHEELS-1:0][NW-1:0]  r_num6;
    logic [MW-1:0]                  r_den6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl6.valid <= 1'b0;
        end else begin
            r_ctrl6.valid <= r_v5;
        end
        r_ctrl6.neg <= r_neg5;
        r_den6      <= r_den5;
        for (int l = 0; l < NUM_WHEELS; l++) begin
            r_num6[l] <= NW'(r_mag5[l]) * NW'(r_fac5);
        end
    end

    // divider
    t_div_ctrl                             w_dctrl;
    logic [NUM_WHEELS-1:0][QUOT_BITS-1:0]  w_quot;

    wsik_divider #(
        .DEN_BITS (MW)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (r_ctrl6),
        .i_num   (r_num6),
        .i_den   (r_den6),
        .o_ctrl  (w_dctrl),
        .o_quot  (w_quot)
    );

    // output stage: restore signs
    logic                   r_vo;
    logic signed [VB-1:0]   r_out [0:NUM_WHEELS-1];
    logic signed [WW-1:0]   w_qx  [0:NUM_WHEELS-1];

    always_comb begin
        for (int l = 0; l < NUM_WHEELS; l++) begin
            w_qx[l] = $signed(WW'(w_quot[l]));
            if (w_dctrl.neg[l]) begin
                w_qx[l] = -w_qx[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else begin
            r_vo <= w_dctrl.valid;
        end
        for (int l = 0; l < NUM_WHEELS; l++) begin
            r_out[l] <= w_qx[l][VB-1:0];
        end
    end

    assign o_valid             = r_vo;
    assign o_left_front_speed  = r_out[0];
    assign o_left_back_speed   = r_out[1];
    assign o_right_front_speed = r_out[2];
    assign o_right_back_speed  = r_out[3];

    `WSIK_ASSERT_DELAY(a_word_out, i_clk, i_rst_n, start && !busy, LAT, o_valid)
    `WSIK_ASSERT_PAST(a_word_in, i_clk, i_rst_n, o_valid, start, LAT)

endmodule
